// ===== rtl/ppeg_pkg.sv =====
// shared types and constants for the pad poll event generator
// no dependencies; imported by ppeg_ctrl, ppeg_dpath and the top level
package ppeg_pkg;

    localparam logic [2:0] EV_CONNECTED    = 3'd0;
    localparam logic [2:0] EV_DISCONNECTED = 3'd1;
    localparam logic [2:0] EV_CHANGE       = 3'd2;
    localparam logic [2:0] EV_PRESSED      = 3'd3;
    localparam logic [2:0] EV_RELEASED     = 3'd4;
    localparam logic [2:0] EV_POLL_END     = 3'd5;

    localparam logic [1:0] OBJ_BUTTON = 2'd0;
    localparam logic [1:0] OBJ_LEFT   = 2'd1;
    localparam logic [1:0] OBJ_RIGHT  = 2'd2;

    localparam logic [1:0] CT_WIRED    = 2'd1;
    localparam logic [1:0] CT_WIRELESS = 2'd2;

    localparam logic [3:0]        SKIP_BIT  = 4'd7;
    localparam logic signed [8:0] BUTTON_ON = 9'sd255;

    localparam int NUM_AXES = 4;
    localparam int NUM_TRIG = 2;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_HEAD = 4'b0010,
        S_SCAN = 4'b0100,
        S_END  = 4'b1000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic head;
        logic scan;
        logic fin;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic present;
        logic conn;
        logic hit;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/pad_poll_event_generator.sv =====
// top level of the pad poll event generator
// depends on ppeg_pkg, ppeg_ctrl and ppeg_dpath
//
// One poll is accepted while the block is idle and is then walked. A poll with
// a pad present, no error flag and an earlier poll behind it is scanned object
// by object, each stick axis, trigger and button in turn; any other poll takes
// a head step (connect or disconnect) instead. Either way a summary beat closes
// the poll. Each event goes out through a single output register, so a stalled
// output only holds the scan at the next changed object. The next poll may be
// accepted while the summary beat still waits to be taken.
module pad_poll_event_generator #(
    parameter int NUM_BUTTONS = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_controller_type,
    input  logic              i_no_controller_error,
    input  logic [15:0]       i_button_word,
    input  logic signed [7:0] i_left_stick_x,
    input  logic signed [7:0] i_left_stick_y,
    input  logic signed [7:0] i_right_stick_x,
    input  logic signed [7:0] i_right_stick_y,
    input  logic [7:0]        i_left_trigger,
    input  logic [7:0]        i_right_trigger,
    input  logic              i_flush_reset,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [2:0]        o_event_kind,
    output logic [1:0]        o_object_kind,
    output logic [3:0]        o_object_number,
    output logic signed [8:0] o_new_value,
    output logic              o_is_attached,
    output logic [1:0]        o_controller_id,
    output logic              o_has_rumble,
    output logic              o_reset_request,
    output logic              o_last
);
    import ppeg_pkg::*;

    localparam int NUM_OBJ = NUM_AXES + NUM_TRIG + NUM_BUTTONS;
    localparam int IDX_W   = $clog2(NUM_OBJ);

    t_cmd             cmd;
    t_status          status;
    logic [IDX_W-1:0] idx;

    ppeg_ctrl #(
        .NUM_OBJ (NUM_OBJ),
        .IDX_W   (IDX_W)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd),
        .o_idx    (idx)
    );

    ppeg_dpath #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .IDX_W       (IDX_W)
    ) u_dpath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .i_idx                 (idx),
        .o_status              (status),
        .i_controller_type     (i_controller_type),
        .i_no_controller_error (i_no_controller_error),
        .i_button_word         (i_button_word),
        .i_left_stick_x        (i_left_stick_x),
        .i_left_stick_y        (i_left_stick_y),
        .i_right_stick_x       (i_right_stick_x),
        .i_right_stick_y       (i_right_stick_y),
        .i_left_trigger        (i_left_trigger),
        .i_right_trigger       (i_right_trigger),
        .i_flush_reset         (i_flush_reset),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_event_kind          (o_event_kind),
        .o_object_kind         (o_object_kind),
        .o_object_number       (o_object_number),
        .o_new_value           (o_new_value),
        .o_is_attached         (o_is_attached),
        .o_controller_id       (o_controller_id),
        .o_has_rumble          (o_has_rumble),
        .o_reset_request       (o_reset_request),
        .o_last                (o_last)
    );

`ifndef SYNTHESIS
    // an accepted poll keeps the input side closed until it is walked
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not held off after accept");

    // the closing beat is always the poll end event
    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_event_kind == EV_POLL_END))
        else $error("last beat is not a poll end");

    // summary fields stay clear on event beats
    a_summary_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (!o_is_attached && !o_reset_request &&
                                  !o_has_rumble && o_controller_id == 2'd0))
        else $error("summary field set on an event beat");

    // a scan step never emits while the output slot is still held
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.scan && status.hit) |-> status.out_free)
        else $error("event emitted into a full output register");
`endif

endmodule

// ===== rtl/ppeg_ctrl.sv =====
// sequencer for one poll: head step or object scan, then summary step
// depends on ppeg_pkg
module ppeg_ctrl #(
    parameter int NUM_OBJ = 18,
    parameter int IDX_W   = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  ppeg_pkg::t_status    i_status,
    output ppeg_pkg::t_cmd       o_cmd,
    output logic [IDX_W-1:0]     o_idx
);
    import ppeg_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_OBJ - 1);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HEAD;
                end
            end
            S_HEAD: begin
                if (i_status.present && !i_status.conn) begin
                    n_idx   = '0;
                    n_state = S_SCAN;
                end else if (i_status.out_free) begin
                    o_cmd.head = 1'b1;
                    n_state    = S_END;
                end
            end
            S_SCAN: begin
                // an unchanged object needs no output slot and never waits
                if (!i_status.hit || i_status.out_free) begin
                    o_cmd.scan = 1'b1;
                    if (r_idx == LAST_IDX) begin
                        n_state = S_END;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_END: begin
                if (i_status.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_idx   = r_idx;

endmodule

// ===== rtl/ppeg_dpath.sv =====
// poll latch, kept pad values, change detect and the output register
// depends on ppeg_pkg; driven by ppeg_ctrl commands
module ppeg_dpath #(
    parameter int NUM_BUTTONS = 12,
    parameter int IDX_W       = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ppeg_pkg::t_cmd       i_cmd,
    input  logic [IDX_W-1:0]     i_idx,
    output ppeg_pkg::t_status    o_status,
    input  logic [1:0]           i_controller_type,
    input  logic                 i_no_controller_error,
    input  logic [15:0]          i_button_word,
    input  logic signed [7:0]    i_left_stick_x,
    input  logic signed [7:0]    i_left_stick_y,
    input  logic signed [7:0]    i_right_stick_x,
    input  logic signed [7:0]    i_right_stick_y,
    input  logic [7:0]           i_left_trigger,
    input  logic [7:0]           i_right_trigger,
    input  logic                 i_flush_reset,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [2:0]           o_event_kind,
    output logic [1:0]           o_object_kind,
    output logic [3:0]           o_object_number,
    output logic signed [8:0]    o_new_value,
    output logic                 o_is_attached,
    output logic [1:0]           o_controller_id,
    output logic                 o_has_rumble,
    output logic                 o_reset_request,
    output logic                 o_last
);
    import ppeg_pkg::*;

    localparam int         BTN_W     = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam logic [3:0] TRIG_NUM0 = 4'(NUM_BUTTONS);

    // latched poll
    logic [1:0]  r_ctype;
    logic        r_err;
    logic [15:0] r_word;
    logic [7:0]  r_axis_in [NUM_AXES];
    logic [7:0]  r_trig_in [NUM_TRIG];
    logic        r_flush;

    // kept pad state
    logic        r_attached, r_init, r_pending, r_rumble, r_rst_issued;
    logic [1:0]  r_kind;
    logic [7:0]  r_axis [NUM_AXES];
    logic [7:0]  r_trig [NUM_TRIG];
    logic        r_btn  [NUM_BUTTONS];

    logic        r_out_valid;

    logic             present, conn, out_free, hit, emit;
    logic             is_axis, is_trig;
    logic [1:0]       a_sel;
    logic             t_sel;
    logic [IDX_W-1:0] btn_off;
    logic [BTN_W-1:0] b_sel;
    logic [3:0]       b_ext, b_pos;
    logic             b_val;
    logic [7:0]       t_old, t_new;
    logic [2:0]       t_kind;
    logic             flush_now;

    logic [2:0]        e_kind;
    logic [1:0]        e_obj;
    logic [3:0]        e_num;
    logic signed [8:0] e_val;
    logic              e_last;

    assign present  = (r_ctype == CT_WIRED) || (r_ctype == CT_WIRELESS);
    assign conn     = r_err || !r_init;
    assign out_free = !r_out_valid || !i_stall;

    // object decode: axes, then triggers, then buttons
    assign is_axis = (i_idx < IDX_W'(NUM_AXES));
    assign is_trig = !is_axis && (i_idx < IDX_W'(NUM_AXES + NUM_TRIG));
    assign a_sel   = i_idx[1:0];
    assign t_sel   = i_idx[0];
    assign btn_off = i_idx - IDX_W'(NUM_AXES + NUM_TRIG);
    assign b_sel   = btn_off[BTN_W-1:0];
    assign b_ext   = 4'(b_sel);
    // word bit 7 is not a button
    assign b_pos   = (b_ext < SKIP_BIT) ? b_ext : b_ext + 4'd1;
    assign b_val   = r_word[b_pos];

    assign t_old = r_trig[t_sel];
    assign t_new = r_trig_in[t_sel];

    always_comb begin
        if (t_old == 8'd0) begin
            t_kind = EV_PRESSED;
        end else if (t_new == 8'd0) begin
            t_kind = EV_RELEASED;
        end else begin
            t_kind = EV_CHANGE;
        end
    end

    assign hit = is_axis ? (r_axis_in[a_sel] != r_axis[a_sel]) :
                 is_trig ? (t_new != t_old) :
                           (b_val != r_btn[b_sel]);

    assign flush_now = r_flush && r_pending;

    always_comb begin
        emit   = 1'b0;
        e_kind = EV_POLL_END;
        e_obj  = OBJ_BUTTON;
        e_num  = '0;
        e_val  = '0;
        e_last = 1'b0;
        if (i_cmd.head) begin
            if (present) begin
                emit   = !r_attached;
                e_kind = EV_CONNECTED;
            end else begin
                emit   = r_attached;
                e_kind = EV_DISCONNECTED;
            end
        end else if (i_cmd.scan) begin
            emit = hit;
            if (is_axis) begin
                e_kind = EV_CHANGE;
                e_obj  = a_sel[1] ? OBJ_RIGHT : OBJ_LEFT;
                e_num  = {3'd0, a_sel[1]};
                e_val  = 9'(signed'(r_axis_in[a_sel]));
            end else if (is_trig) begin
                e_kind = t_kind;
                e_num  = TRIG_NUM0 + {3'd0, t_sel};
                e_val  = {1'b0, t_new};
            end else begin
                e_kind = b_val ? EV_PRESSED : EV_RELEASED;
                e_num  = b_ext;
                e_val  = b_val ? BUTTON_ON : 9'sd0;
            end
        end else if (i_cmd.fin) begin
            emit   = 1'b1;
            e_kind = EV_POLL_END;
            e_last = 1'b1;
        end
    end

    assign o_status = '{present: present, conn: conn, hit: hit, out_free: out_free};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ctype      <= i_controller_type;
            r_err        <= i_no_controller_error;
            r_word       <= i_button_word;
            r_axis_in[0] <= i_left_stick_x;
            r_axis_in[1] <= i_left_stick_y;
            r_axis_in[2] <= i_right_stick_x;
            r_axis_in[3] <= i_right_stick_y;
            r_trig_in[0] <= i_left_trigger;
            r_trig_in[1] <= i_right_trigger;
            r_flush      <= i_flush_reset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attached   <= 1'b0;
            r_init       <= 1'b0;
            r_pending    <= 1'b0;
            r_rumble     <= 1'b0;
            r_rst_issued <= 1'b0;
            r_kind       <= '0;
            for (int i = 0; i < NUM_AXES; i++) r_axis[i] <= '0;
            for (int i = 0; i < NUM_TRIG; i++) r_trig[i] <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++) r_btn[i] <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_rst_issued <= 1'b0;
            end
            if (i_cmd.head) begin
                if (present) begin
                    r_pending  <= 1'b1;
                    r_kind     <= r_ctype;
                    r_rumble   <= (r_ctype == CT_WIRED);
                    r_attached <= 1'b1;
                    if (!r_attached) begin
                        r_rst_issued <= 1'b1;
                    end
                end else begin
                    if (r_attached) begin
                        for (int i = 0; i < NUM_AXES; i++) r_axis[i] <= '0;
                        for (int i = 0; i < NUM_TRIG; i++) r_trig[i] <= '0;
                        for (int i = 0; i < NUM_BUTTONS; i++) r_btn[i] <= 1'b0;
                    end
                    r_attached <= 1'b0;
                end
            end
            if (i_cmd.scan && hit) begin
                if (is_axis) begin
                    r_axis[a_sel] <= r_axis_in[a_sel];
                end else if (is_trig) begin
                    r_trig[t_sel] <= t_new;
                end else begin
                    r_btn[b_sel] <= b_val;
                end
            end
            if (i_cmd.fin) begin
                r_init <= 1'b1;
                if (flush_now) begin
                    r_pending    <= 1'b0;
                    r_rst_issued <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_event_kind    <= e_kind;
            o_object_kind   <= e_obj;
            o_object_number <= e_num;
            o_new_value     <= e_val;
            o_last          <= e_last;
            o_is_attached   <= e_last & r_attached;
            o_controller_id <= e_last ? r_kind : 2'd0;
            o_has_rumble    <= e_last & r_rumble;
            o_reset_request <= e_last & (r_rst_issued | flush_now);
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for pad_poll_event_generator
// depends on ppeg_pkg and the rtl; an event book class predicts and checks the event beats
`timescale 1ns / 1ps

module testbench;
    import ppeg_pkg::*;

    localparam int NUM_BUTTONS = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_POLLS = 500;

    // probe codes with no name in the package
    localparam logic [1:0] CT_NONE  = 2'd0;
    localparam logic [1:0] CT_BOGUS = 2'd3;

    typedef struct packed {
        logic [1:0]      ctype;
        logic            err;
        logic [15:0]     buttons;
        logic [3:0][7:0] axis;    // left x, left y, right x, right y
        logic [1:0][7:0] trig;    // left, right
        logic            flush;
    } t_poll;

    typedef struct packed {
        logic [2:0]        kind;
        logic [1:0]        obj;
        logic [3:0]        num;
        logic signed [8:0] value;
        logic              attached;
        logic [1:0]        cid;
        logic              rumble;
        logic              rst_req;
        logic              last;
    } t_pad_event;

    class pad_event_book;
        t_pad_event              pending_events[$];
        int                      mismatches;
        bit                      attached;
        bit                      inited;
        bit                      pend_reset;
        bit                      rumble;
        logic [1:0]              cid;
        logic [3:0][7:0]         axis_last;
        logic [1:0][7:0]         trig_last;
        logic [NUM_BUTTONS-1:0]  btn_last;

        function new();
            mismatches = 0;
            attached   = 0;
            inited     = 0;
            pend_reset = 0;
            rumble     = 0;
            cid        = '0;
            axis_last  = '0;
            trig_last  = '0;
            btn_last   = '0;
        endfunction

        function void push_event(logic [2:0] kind, logic [1:0] obj, logic [3:0] num,
                                 logic signed [8:0] value);
            t_pad_event e;
            e       = '0;
            e.kind  = kind;
            e.obj   = obj;
            e.num   = num;
            e.value = value;
            pending_events.push_back(e);
        endfunction

        // work out every event one accepted poll causes
        function void take_poll(t_poll p);
            t_pad_event sum;
            bit         issued;
            logic [2:0] kind;
            logic       v;
            int         b;
            issued = 0;
            if (p.ctype == CT_WIRED || p.ctype == CT_WIRELESS) begin
                if (p.err || !inited) begin
                    pend_reset = 1;
                    cid        = p.ctype;
                    rumble     = (p.ctype == CT_WIRED);
                    if (!attached) begin
                        push_event(EV_CONNECTED, OBJ_BUTTON, 4'd0, 9'sd0);
                        issued = 1;
                    end
                    attached = 1;
                end else begin
                    for (int i = 0; i < NUM_AXES; i++) begin
                        if (p.axis[i] != axis_last[i]) begin
                            push_event(EV_CHANGE, (i < 2) ? OBJ_LEFT : OBJ_RIGHT,
                                       (i < 2) ? 4'd0 : 4'd1,
                                       {p.axis[i][7], p.axis[i]});
                            axis_last[i] = p.axis[i];
                        end
                    end
                    for (int i = 0; i < NUM_TRIG; i++) begin
                        if (p.trig[i] != trig_last[i]) begin
                            kind = EV_CHANGE;
                            if (trig_last[i] == 8'd0)
                                kind = EV_PRESSED;
                            else if (p.trig[i] == 8'd0)
                                kind = EV_RELEASED;
                            push_event(kind, OBJ_BUTTON, 4'(NUM_BUTTONS + i),
                                       {1'b0, p.trig[i]});
                            trig_last[i] = p.trig[i];
                        end
                    end
                    for (int i = 0; i < NUM_BUTTONS; i++) begin
                        // the raw word has a hole at the skipped bit
                        b = (i < SKIP_BIT) ? i : i + 1;
                        v = (b < 16) ? p.buttons[b] : 1'b0;
                        if (v != btn_last[i]) begin
                            btn_last[i] = v;
                            push_event(v ? EV_PRESSED : EV_RELEASED, OBJ_BUTTON, 4'(i),
                                       v ? BUTTON_ON : 9'sd0);
                        end
                    end
                end
            end else begin
                if (attached) begin
                    axis_last = '0;
                    trig_last = '0;
                    btn_last  = '0;
                    push_event(EV_DISCONNECTED, OBJ_BUTTON, 4'd0, 9'sd0);
                end
                attached = 0;
            end
            inited = 1;
            if (p.flush && pend_reset) begin
                issued     = 1;
                pend_reset = 0;
            end
            sum          = '0;
            sum.kind     = EV_POLL_END;
            sum.attached = attached;
            sum.cid      = cid;
            sum.rumble   = rumble;
            sum.rst_req  = issued;
            sum.last     = 1'b1;
            pending_events.push_back(sum);
        endfunction

        function void report_diff(string field, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void match_event(t_pad_event got);
            t_pad_event want;
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected event beat, expected none actual kind %0d",
                         $time, got.kind);
                mismatches++;
                return;
            end
            want = pending_events.pop_front();
            report_diff("event_kind", want.kind, got.kind);
            report_diff("object_kind", want.obj, got.obj);
            report_diff("object_number", want.num, got.num);
            report_diff("new_value", want.value, got.value);
            report_diff("is_attached", want.attached, got.attached);
            report_diff("controller_id", want.cid, got.cid);
            report_diff("has_rumble", want.rumble, got.rumble);
            report_diff("reset_request", want.rst_req, got.rst_req);
            report_diff("last", want.last, got.last);
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [1:0]        i_controller_type = '0;
    logic              i_no_controller_error = 1'b0;
    logic [15:0]       i_button_word = '0;
    logic signed [7:0] i_left_stick_x = '0;
    logic signed [7:0] i_left_stick_y = '0;
    logic signed [7:0] i_right_stick_x = '0;
    logic signed [7:0] i_right_stick_y = '0;
    logic [7:0]        i_left_trigger = '0;
    logic [7:0]        i_right_trigger = '0;
    logic              i_flush_reset = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [2:0]        o_event_kind;
    logic [1:0]        o_object_kind;
    logic [3:0]        o_object_number;
    logic signed [8:0] o_new_value;
    logic              o_is_attached;
    logic [1:0]        o_controller_id;
    logic              o_has_rumble;
    logic              o_reset_request;
    logic              o_last;

    pad_event_book book = new();
    bit            calm = 1'b0;    // no idling on either side while set
    int            cycles = 0;
    t_poll         prev_poll;

    pad_poll_event_generator #(.NUM_BUTTONS(NUM_BUTTONS)) dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_stall               (o_stall),
        .i_controller_type     (i_controller_type),
        .i_no_controller_error (i_no_controller_error),
        .i_button_word         (i_button_word),
        .i_left_stick_x        (i_left_stick_x),
        .i_left_stick_y        (i_left_stick_y),
        .i_right_stick_x       (i_right_stick_x),
        .i_right_stick_y       (i_right_stick_y),
        .i_left_trigger        (i_left_trigger),
        .i_right_trigger       (i_right_trigger),
        .i_flush_reset         (i_flush_reset),
        .o_valid               (o_valid),
        .i_stall               (i_stall),
        .o_event_kind          (o_event_kind),
        .o_object_kind         (o_object_kind),
        .o_object_number       (o_object_number),
        .o_new_value           (o_new_value),
        .o_is_attached         (o_is_attached),
        .o_controller_id       (o_controller_id),
        .o_has_rumble          (o_has_rumble),
        .o_reset_request       (o_reset_request),
        .o_last                (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: check each taken beat, stall at random
    always @(posedge i_clk) begin
        t_pad_event got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.kind     = o_event_kind;
            got.obj      = o_object_kind;
            got.num      = o_object_number;
            got.value    = o_new_value;
            got.attached = o_is_attached;
            got.cid      = o_controller_id;
            got.rumble   = o_has_rumble;
            got.rst_req  = o_reset_request;
            got.last     = o_last;
            book.match_event(got);
        end
        i_stall <= !calm && ($urandom_range(0, 99) < 31);
    end

    function automatic t_poll mk_poll(logic [1:0] ctype, logic err, logic [15:0] buttons,
                                      logic [7:0] lx, logic [7:0] ly, logic [7:0] rx,
                                      logic [7:0] ry, logic [7:0] lt, logic [7:0] rt,
                                      logic flush);
        t_poll p;
        p.ctype   = ctype;
        p.err     = err;
        p.buttons = buttons;
        p.axis[0] = lx;
        p.axis[1] = ly;
        p.axis[2] = rx;
        p.axis[3] = ry;
        p.trig[0] = lt;
        p.trig[1] = rt;
        p.flush   = flush;
        return p;
    endfunction

    // mostly polls with a pad present that move a few objects at a time
    function automatic t_poll roll_poll(t_poll prev);
        t_poll p;
        int    r;
        p = prev;
        r = $urandom_range(0, 99);
        if (r < 6)
            p.ctype = CT_NONE;
        else if (r < 10)
            p.ctype = CT_BOGUS;
        else if (r < 55)
            p.ctype = CT_WIRED;
        else
            p.ctype = CT_WIRELESS;
        p.err = ($urandom_range(0, 99) < 8);
        for (int i = 0; i < 4; i++) begin
            r = $urandom_range(0, 9);
            if (r == 4)
                p.axis[i] = 8'h80;
            else if (r == 5)
                p.axis[i] = 8'h7f;
            else if (r > 5)
                p.axis[i] = 8'($urandom_range(0, 255));
        end
        for (int i = 0; i < 2; i++) begin
            r = $urandom_range(0, 9);
            if (r == 4 || r == 5)
                p.trig[i] = 8'd0;
            else if (r == 6)
                p.trig[i] = 8'hff;
            else if (r > 6)
                p.trig[i] = 8'($urandom_range(0, 255));
        end
        r = $urandom_range(0, 3);
        if (r == 1)
            p.buttons = 16'($urandom_range(0, 65535));
        else if (r > 1)
            p.buttons = p.buttons ^ (16'd1 << $urandom_range(0, 15));
        p.flush = ($urandom_range(0, 99) < 30);
        return p;
    endfunction

    task automatic drive_poll(t_poll p);
        while (!calm && $urandom_range(0, 99) < 31) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid               <= 1'b1;
        i_controller_type     <= p.ctype;
        i_no_controller_error <= p.err;
        i_button_word         <= p.buttons;
        i_left_stick_x        <= p.axis[0];
        i_left_stick_y        <= p.axis[1];
        i_right_stick_x       <= p.axis[2];
        i_right_stick_y       <= p.axis[3];
        i_left_trigger        <= p.trig[0];
        i_right_trigger       <= p.trig[1];
        i_flush_reset         <= p.flush;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        book.take_poll(p);
        prev_poll = p;
    endtask

    // hold the sender off until every predicted beat has been taken
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (book.pending_events.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        prev_poll = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first poll with no pad, then a pad that shows up without the error flag
        drive_poll(mk_poll(CT_NONE, 1'b0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
                           8'h00, 8'h00, 1'b1));
        drive_poll(mk_poll(CT_WIRED, 1'b0, 16'hffff, 8'h7f, 8'h80, 8'h80, 8'h7f,
                           8'hff, 8'hff, 1'b0));
        // connection, pending reset, then flushed on the next tick
        drive_poll(mk_poll(CT_WIRED, 1'b1, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
                           8'h00, 8'h00, 1'b0));
        drive_poll(mk_poll(CT_WIRED, 1'b0, 16'h0000, 8'h80, 8'h7f, 8'h7f, 8'h80,
                           8'h01, 8'hff, 1'b1));
        // trigger change between nonzero levels, skipped bit alone
        drive_poll(mk_poll(CT_WIRED, 1'b0, 16'h0080, 8'hff, 8'h01, 8'h00, 8'h80,
                           8'h80, 8'h01, 1'b0));
        drive_poll(mk_poll(CT_WIRED, 1'b0, 16'h1f7f, 8'hff, 8'h01, 8'h00, 8'h80,
                           8'h00, 8'h00, 1'b0));
        drive_poll(mk_poll(CT_WIRED, 1'b0, 16'he000, 8'hff, 8'h01, 8'h00, 8'h80,
                           8'h00, 8'h00, 1'b1));
        // error flag while attached: no connected beat, becomes wireless
        drive_poll(mk_poll(CT_WIRELESS, 1'b1, 16'h5555, 8'h11, 8'h22, 8'h33, 8'h44,
                           8'h55, 8'h66, 1'b0));
        drive_poll(mk_poll(CT_WIRELESS, 1'b0, 16'haaaa, 8'h11, 8'h22, 8'h33, 8'h44,
                           8'h55, 8'h66, 1'b1));
        // unknown probe code disconnects, second no-pad poll does nothing
        drive_poll(mk_poll(CT_BOGUS, 1'b0, 16'hffff, 8'h7f, 8'h7f, 8'h7f, 8'h7f,
                           8'hff, 8'hff, 1'b0));
        drive_poll(mk_poll(CT_NONE, 1'b1, 16'hffff, 8'h00, 8'h00, 8'h00, 8'h00,
                           8'h00, 8'h00, 1'b1));
        // present but detached: events while is_attached stays low
        drive_poll(mk_poll(CT_WIRELESS, 1'b0, 16'h0f0f, 8'h80, 8'h80, 8'h80, 8'h80,
                           8'h10, 8'h00, 1'b0));
        drive_poll(mk_poll(CT_WIRELESS, 1'b1, 16'h0f0f, 8'h80, 8'h80, 8'h80, 8'h80,
                           8'h10, 8'h00, 1'b1));
        drive_poll(mk_poll(CT_WIRELESS, 1'b0, 16'hf0f0, 8'h7f, 8'h00, 8'hc0, 8'h40,
                           8'h00, 8'hfe, 1'b1));
        drive_poll(mk_poll(CT_NONE, 1'b0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00,
                           8'h00, 8'h00, 1'b0));
        drive_poll(mk_poll(CT_WIRED, 1'b1, 16'hffff, 8'h7f, 8'h80, 8'h7f, 8'h80,
                           8'hff, 8'hff, 1'b0));
        drive_poll(mk_poll(CT_WIRED, 1'b0, 16'hffff, 8'h7f, 8'h80, 8'h7f, 8'h80,
                           8'hff, 8'hff, 1'b1));

        wait_drained();

        for (int n = 0; n < RANDOM_POLLS; n++) begin
            calm = (n >= 150 && n < 250);
            if (n == 320)
                wait_drained();
            drive_poll(roll_poll(prev_poll));
        end
        calm = 1'b0;

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (book.mismatches == 0 && book.pending_events.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
